>>> design/kst_pkg.sv
// kst_pkg: shared types and constants of the key set table.
// Request and status codes, field widths and default sizes.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

  // Default table geometry
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  // Fixed payload widths
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_FOUND    = 3'd5
  } status_t;

  // Finished request handed from the sequencer to the output stage
  typedef struct packed {
    logic    fire;
    status_t status;
  } done_t;

endpackage : kst_pkg

`default_nettype wire

>>> design/kst_if.sv
// kst_req_if / kst_rsp_if: valid/ready channels of the key set table.
// Depends on kst_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface kst_req_if;
  import kst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface : kst_req_if

interface kst_rsp_if;
  import kst_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  member_count;

  modport source (output valid, output status, output member_count, input ready);
  modport sink   (input valid, input status, input member_count, output ready);
endinterface : kst_rsp_if

`default_nettype wire

>>> design/kst_ram.sv
// kst_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : kst_ram

`default_nettype wire

>>> design/kst_ctrl.sv
// kst_ctrl: sequencer of the key set table. Clears the valid marks after
// reset, then scans the table one slot a cycle with a single compare unit
// and applies the add/remove. Depends on kst_pkg; drives two kst_ram ports.
`timescale 1ns / 1ps
`default_nettype none

module kst_ctrl #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = kst_pkg::KEY_BITS_DEF,
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request side
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kst_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic signed [kst_pkg::KEY_W-1:0] in_key,
  // output stage
  input  wire logic                          slot_free,
  output kst_pkg::done_t                     done,
  output logic [CNT_W-1:0]                   count,
  // key store
  output logic                               key_we,
  output logic [IDX_W-1:0]                   key_waddr,
  output logic [KEY_BITS-1:0]                key_wdata,
  input  wire logic [KEY_BITS-1:0]           key_rdata,
  // valid marks
  output logic                               vld_we,
  output logic [IDX_W-1:0]                   vld_waddr,
  output logic                               vld_wdata,
  input  wire logic                          vld_rdata,
  // shared read port address
  output logic                               rd_en,
  output logic [IDX_W-1:0]                   rd_addr
);
  import kst_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_LAST   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [REQ_W-1:0]  req_r;
  logic [IDX_W:0]    scan_idx_r;
  logic              cmp_pend_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r, free_r;
  logic [IDX_W-1:0]  hit_idx_r, free_idx_r;
  logic [IDX_W-1:0]  clr_idx_r;
  status_t           status_r;
  logic [CNT_W-1:0]  count_r;

  logic              accept;
  logic              scan_end;
  logic              clr_end;
  logic              add_ok, rm_ok;
  logic              match, empty;
  logic [63:0]       key_ext;
  status_t           status_nxt;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign scan_end = (scan_idx_r == (IDX_W + 1)'(CAPACITY - 1));
  assign clr_end  = (clr_idx_r == IDX_W'(CAPACITY - 1));
  // the input key is sign-extended to KEY_BITS (truncated if KEY_BITS < KEY_W)
  assign key_ext  = {{(64 - KEY_W){in_key[KEY_W-1]}}, in_key};

  // shared compare unit, one slot per cycle
  assign match = vld_rdata && (key_rdata == key_r);
  assign empty = !vld_rdata;

  assign add_ok = (req_r == REQ_ADD) && !hit_r && free_r;
  assign rm_ok  = (req_r == REQ_REMOVE) && hit_r;

  always_comb begin
    priority if (req_r == REQ_ADD) begin
      status_nxt = hit_r ? ST_PRESENT : (free_r ? ST_ADDED : ST_FULL);
    end else if (req_r == REQ_REMOVE) begin
      status_nxt = hit_r ? ST_REMOVED : ST_NOTFOUND;
    end else begin
      status_nxt = hit_r ? ST_FOUND : ST_NOTFOUND;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_end) state_nxt = S_IDLE;
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (scan_end) state_nxt = S_LAST;
      S_LAST:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DONE;
      S_DONE:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_idx_r  <= '0;
      cmp_pend_r <= 1'b0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      cmp_pend_r <= (state_r == S_SCAN);
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (state_r == S_UPDATE) begin
        if (add_ok) begin
          count_r <= count_r + CNT_W'(1);
        end else if (rm_ok) begin
          count_r <= count_r - CNT_W'(1);
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r      <= key_ext[KEY_BITS-1:0];
      req_r      <= in_req_type;
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      if (state_r == S_SCAN) begin
        scan_idx_r <= scan_idx_r + (IDX_W + 1)'(1);
        cmp_idx_r  <= scan_idx_r[IDX_W-1:0];
      end
      // first match and lowest free slot win
      if (cmp_pend_r) begin
        if (match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
        if (empty && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
    end
    if (state_r == S_UPDATE) begin
      status_r <= status_nxt;
    end
  end

  assign rd_en   = (state_r == S_SCAN);
  assign rd_addr = scan_idx_r[IDX_W-1:0];

  assign key_we    = (state_r == S_UPDATE) && add_ok;
  assign key_waddr = free_idx_r;
  assign key_wdata = key_r;

  assign vld_we    = (state_r == S_CLEAR) || ((state_r == S_UPDATE) && (add_ok || rm_ok));
  assign vld_waddr = (state_r == S_CLEAR) ? clr_idx_r : (add_ok ? free_idx_r : hit_idx_r);
  assign vld_wdata = (state_r == S_UPDATE) && add_ok;

  assign done.fire   = (state_r == S_DONE) && slot_free;
  assign done.status = status_r;
  assign count       = count_r;

endmodule : kst_ctrl

`default_nettype wire

>>> design/key_set_table_top.sv
// Key set table: holds up to CAPACITY distinct signed keys.
// Request channel in_ch carries req_type (0 add, 1 remove, 2 look up; 3 acts
// as a look up) and key. Response channel out_ch returns one status per
// request plus the member count after it, in request order.
// After reset the block runs a clearing pass over the valid marks of all
// CAPACITY slots; in_ch.ready stays low meanwhile.
// A request is worked on alone: it is taken in IDLE, the table is scanned one
// slot a cycle through the registered read port of the slot memories, then
// S_LAST finishes the last compare, S_UPDATE applies the update and S_DONE
// loads the response register once the output slot is free. The next
// request can be taken only after the sequencer is back in IDLE.
// The response sits in an output register; the next request is accepted and
// scanned while it waits. If the receiver still stalls when that request is
// done, the sequencer holds its result and takes no further request.
// Depends on kst_pkg, kst_if, kst_ram and kst_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module key_set_table_top #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = kst_pkg::KEY_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kst_req_if.sink    in_ch,
  kst_rsp_if.source  out_ch
);
  import kst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  done_t               done;
  logic [CNT_W-1:0]    count;
  logic                slot_free;
  logic                key_we, vld_we, vld_wdata, vld_rdata, rd_en;
  logic [IDX_W-1:0]    key_waddr, vld_waddr, rd_addr;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  // count reported modulo 2^COUNT_W
  assign count_ext = {{COUNT_W{1'b0}}, count};

  kst_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_key      (in_ch.key),
    .slot_free   (slot_free),
    .done        (done),
    .count       (count),
    .key_we      (key_we),
    .key_waddr   (key_waddr),
    .key_wdata   (key_wdata),
    .key_rdata   (key_rdata),
    .vld_we      (vld_we),
    .vld_waddr   (vld_waddr),
    .vld_wdata   (vld_wdata),
    .vld_rdata   (vld_rdata),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  kst_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (key_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rdata)
  );

  kst_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_vld_ram (
    .clk     (clk),
    .wr_en   (vld_we),
    .wr_addr (vld_waddr),
    .wr_data (vld_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (vld_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.fire) begin
      out_status_r <= done.status;
      out_count_r  <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.member_count = out_count_r;

endmodule : key_set_table_top

`default_nettype wire

>>> design/kst_chk.sv
// kst_chk: port-level checks of the key set table, bound to the top level.
// Depends on kst_pkg and key_set_table_top.
`timescale 1ns / 1ps
`default_nettype none

module kst_chk #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [kst_pkg::STATUS_W-1:0] status,
  input wire logic [kst_pkg::COUNT_W-1:0]  member_count
);
  import kst_pkg::*;

  localparam logic [COUNT_W+31:0] CAP_EXT = (COUNT_W + 32)'(CAPACITY);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(member_count))
    else $error("response changed while stalled");

  // one request at a time: ready drops after every accepted request
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a response cannot appear right after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("response too early");

  // full is only reported with the table at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |-> member_count == CAP_EXT[COUNT_W-1:0])
    else $error("table full reported below capacity");

  // a successful add leaves at least one member (checked for CAPACITY < 32)
  a_add_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_ADDED) && (CAPACITY < 32) |-> member_count != '0)
    else $error("add left an empty table");

endmodule : kst_chk

bind key_set_table_top kst_chk #(
  .CAPACITY (CAPACITY)
) u_kst_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .member_count (out_ch.member_count)
);

`default_nettype wire
